// File: src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by wsd_parser and websocket_frame_deframer.
package wsd_pkg;

  typedef enum logic [4:0] {
    PhHdr0    = 5'b00001,
    PhHdr1    = 5'b00010,
    PhExt     = 5'b00100,
    PhPayload = 5'b01000,
    PhHalt    = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    StOpen   = 2'd0,
    StClosed = 2'd1,
    StError  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KindSkip = 2'd0,
    KindMsg  = 2'd1,
    KindPing = 2'd2
  } kind_e;

  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [6:0] PingMax   = 7'd125;

  typedef struct packed {
    kind_e   kind;
    logic    msg_end;
    status_e status;
  } result_t;

  function automatic logic is_data_op(input logic [3:0] op);
    return (op == OpCont) || (op == OpText) || (op == OpBin);
  endfunction

endpackage

// File: src/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg and wsd_parser.
//
//   channel | signals                                           | direction
//   rx      | rx_valid_i, rx_stall_o, rx_byte_i                 | in
//   out     | out_valid_o, out_stall_i, out_byte_o, byte_kind_o, | out
//           | message_end_o, link_status_o                      |
//
// One byte per cycle sustained while the output is not stalled; a byte reaches the output
// through the input register, then parser logic into the result register.
// Reset clears the parse state, the sticky link status and both valid flags.
// Output stall holds the result register; the input register keeps taking a byte
// while a result waits, and rx_stall_o rises only when both registers are full.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] byte_kind_o,
  output logic       message_end_o,
  output logic [1:0] link_status_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  result_t    out_res_q;
  result_t    res;
  logic       out_free;
  logic       adv;
  logic       in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign rx_stall_o = in_vld_q && !out_free;
  assign in_take    = rx_valid_i && !rx_stall_o;

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (adv) in_vld_q <= 1'b0;
      if (out_free) out_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_byte_q <= rx_byte_i;
    if (adv) begin
      out_byte_q <= in_byte_q;
      out_res_q  <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_byte_o    = out_byte_q;
  assign byte_kind_o   = out_res_q.kind;
  assign message_end_o = out_res_q.msg_end;
  assign link_status_o = out_res_q.status;

endmodule

// File: src/wsd_parser.sv
// Frame header/payload parser: holds the parse state and classifies one byte per step.
// Depends on wsd_pkg.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic        final_q, final_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] pay_left_q, pay_left_d;
  logic        nonempty_q, nonempty_d;
  logic [6:0]  ping_cnt_q, ping_cnt_d;
  status_e     status_q, status_d;

  logic        eof;
  logic        msg_end;
  kind_e       kind;
  logic [6:0]  len7;

  always_comb begin
    phase_d    = phase_q;
    final_d    = final_q;
    opcode_d   = opcode_q;
    ext_left_d = ext_left_q;
    pay_left_d = pay_left_q;
    nonempty_d = nonempty_q;
    ping_cnt_d = ping_cnt_q;
    status_d   = status_q;
    eof        = 1'b0;
    msg_end    = 1'b0;
    kind       = KindSkip;
    len7       = byte_i[6:0];

    unique case (phase_q)
      PhHdr0: begin
        final_d  = byte_i[7];
        opcode_d = byte_i[3:0];
        phase_d  = PhHdr1;
      end
      PhHdr1: begin
        if (byte_i[7]) begin
          status_d = StError;
          phase_d  = PhHalt;
        end else begin
          ping_cnt_d = '0;
          pay_left_d = '0;
          if (len7 == Len16Code) begin
            ext_left_d = Ext16Bytes;
            phase_d    = PhExt;
          end else if (len7 == Len64Code) begin
            ext_left_d = Ext64Bytes;
            phase_d    = PhExt;
          end else begin
            pay_left_d = {57'd0, len7};
            if (len7 == '0) eof = 1'b1;
            else phase_d = PhPayload;
          end
        end
      end
      PhExt: begin
        pay_left_d = {pay_left_q[55:0], byte_i};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == '0) begin
          if (pay_left_d == '0) eof = 1'b1;
          else phase_d = PhPayload;
        end
      end
      PhPayload: begin
        if (is_data_op(opcode_q)) begin
          kind       = KindMsg;
          nonempty_d = 1'b1;
        end else if ((opcode_q == OpPing) && (ping_cnt_q < PingMax)) begin
          kind       = KindPing;
          ping_cnt_d = ping_cnt_q + 7'd1;
        end
        pay_left_d = pay_left_q - 64'd1;
        if (pay_left_d == '0) eof = 1'b1;
      end
      default: ;
    endcase

    if (eof) begin
      phase_d = PhHdr0;
      if (opcode_d == OpClose) begin
        status_d = StClosed;
        phase_d  = PhHalt;
      end else if (final_d && nonempty_d && is_data_op(opcode_d)) begin
        msg_end    = 1'b1;
        nonempty_d = 1'b0;
      end
    end
  end

  assign res_o = '{kind: kind, msg_end: msg_end, status: status_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      final_q    <= 1'b0;
      opcode_q   <= '0;
      ext_left_q <= '0;
      pay_left_q <= '0;
      nonempty_q <= 1'b0;
      ping_cnt_q <= '0;
      status_q   <= StOpen;
    end else if (step_i) begin
      phase_q    <= phase_d;
      final_q    <= final_d;
      opcode_q   <= opcode_d;
      ext_left_q <= ext_left_d;
      pay_left_q <= pay_left_d;
      nonempty_q <= nonempty_d;
      ping_cnt_q <= ping_cnt_d;
      status_q   <= status_d;
    end
  end

endmodule
